// File: rtl/core/p1ts_pkg.sv
package p1ts_pkg;

  localparam int IDX_W   = 20;
  localparam int COORD_W = 18;
  localparam int DIFF_W  = COORD_W + 1;     // edge vector component
  localparam int PROD_W  = 2 * DIFF_W;      // one product of two components
  localparam int SUM_W   = PROD_W + 1;      // det, dot products (signed)
  localparam int NUM_W   = SUM_W + 2;       // entry numerators (signed)
  localparam int DET_W   = SUM_W - 1;       // |det|
  localparam int MAG_W   = DET_W;           // |numerator|, below 2^37
  localparam int FRAC_SH = 16;
  localparam int N_W     = MAG_W + FRAC_SH; // dividend mag*2^16 + det
  localparam int D_W     = DET_W + 1;       // divisor 2*det
  localparam int QB      = 33;              // quotient bits resolved
  localparam int ENT_W   = 32;
  localparam int N_ENT   = 6;

  localparam int PRE_ST  = 5;               // stages ahead of the dividers
  localparam int LANE_ST = QB + 3;          // prep, range check, steps, clip
  localparam int NS      = PRE_ST + LANE_ST;

  localparam logic [ENT_W-1:0] ENT_MAX = {1'b0, {(ENT_W-1){1'b1}}};
  localparam logic [ENT_W-1:0] ENT_MIN = {1'b1, {(ENT_W-1){1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ENT_W-1:0]          entry_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [DET_W-1:0] det;
    logic             zero;
  } div_req_t;

  typedef struct packed {
    entry_t value;
    logic   sat;
  } div_res_t;

endpackage

// File: rtl/core/p1ts_div_lane.sv
module p1ts_div_lane (
  input  logic                          clk,
  input  logic [p1ts_pkg::LANE_ST-1:0]  ld,
  input  p1ts_pkg::div_req_t            req,
  output p1ts_pkg::div_res_t            res
);
  import p1ts_pkg::*;

  typedef struct packed {
    logic [D_W-1:0] p;
    logic [QB-1:0]  q;
    logic [QB-1:0]  nlo;
    logic [D_W-1:0] den;
    logic           neg;
    logic           zero;
    logic           ovf;
  } step_t;

  logic [N_W-1:0] num_a_r;
  logic [D_W-1:0] den_a_r;
  logic           neg_a_r;
  logic           zero_a_r;

  step_t          st_r   [0:QB];
  step_t          st_nxt [0:QB];
  div_res_t       res_r;
  div_res_t       res_nxt;

  // dividend carries the rounding offset: q = floor((mag*2^16 + d) / 2d)
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      num_a_r  <= {req.mag, {FRAC_SH{1'b0}}} + N_W'(req.det);
      den_a_r  <= {req.det, 1'b0};
      neg_a_r  <= req.neg;
      zero_a_r <= req.zero;
    end
  end

  // top bits above the quotient range: if they already reach the divisor, clip
  always_comb begin
    st_nxt[0].p    = D_W'(num_a_r[N_W-1:QB]);
    st_nxt[0].q    = '0;
    st_nxt[0].nlo  = num_a_r[QB-1:0];
    st_nxt[0].den  = den_a_r;
    st_nxt[0].neg  = neg_a_r;
    st_nxt[0].zero = zero_a_r;
    st_nxt[0].ovf  = D_W'(num_a_r[N_W-1:QB]) >= den_a_r;
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      st_r[0] <= st_nxt[0];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         ge;

    always_comb begin
      trial = {st_r[j].p, st_r[j].nlo[QB-1]};
      diff  = trial - {1'b0, st_r[j].den};
      ge    = trial >= {1'b0, st_r[j].den};
      st_nxt[j+1]      = st_r[j];
      st_nxt[j+1].p    = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      st_nxt[j+1].q    = {st_r[j].q[QB-2:0], ge};
      st_nxt[j+1].nlo  = {st_r[j].nlo[QB-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (ld[j+2]) begin
        st_r[j+1] <= st_nxt[j+1];
      end
    end
  end

  always_comb begin
    res_nxt.value = '0;
    res_nxt.sat   = 1'b0;
    if (st_r[QB].zero) begin
      res_nxt.value = '0;
      res_nxt.sat   = 1'b0;
    end else if (!st_r[QB].neg) begin
      if (st_r[QB].ovf || (st_r[QB].q[QB-1:ENT_W-1] != '0)) begin
        res_nxt.value = ENT_MAX;
        res_nxt.sat   = 1'b1;
      end else begin
        res_nxt.value = st_r[QB].q[ENT_W-1:0];
      end
    end else begin
      if (st_r[QB].ovf || st_r[QB].q[QB-1] ||
          (st_r[QB].q[ENT_W-1] && (st_r[QB].q[ENT_W-2:0] != '0))) begin
        res_nxt.value = ENT_MIN;
        res_nxt.sat   = 1'b1;
      end else begin
        res_nxt.value = ENT_W'(0) - st_r[QB].q[ENT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[LANE_ST-1]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/core/p1_triangle_stiffness_unit.sv
// An accepted input word passes through 41 stages before its output word is valid.
// Throughput: one triangle per cycle while the output is not stalled; the six
// 33-step restoring dividers are fully pipelined, one quotient bit per stage.
// Stalls collapse bubbles: stage i loads on out_ready or if any stage from i on is free.
// Reset (rst_n low, synchronous) clears all valid bits; datapath holds no reset.
module p1_triangle_stiffness_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [p1ts_pkg::IDX_W-1:0]         in_element_index,
  input  logic signed [p1ts_pkg::COORD_W-1:0] in_corner1_x,
  input  logic signed [p1ts_pkg::COORD_W-1:0] in_corner1_y,
  input  logic signed [p1ts_pkg::COORD_W-1:0] in_corner2_x,
  input  logic signed [p1ts_pkg::COORD_W-1:0] in_corner2_y,
  input  logic signed [p1ts_pkg::COORD_W-1:0] in_corner3_x,
  input  logic signed [p1ts_pkg::COORD_W-1:0] in_corner3_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [p1ts_pkg::IDX_W-1:0]         out_tag_index,
  output logic signed [p1ts_pkg::ENT_W-1:0]  out_k11,
  output logic signed [p1ts_pkg::ENT_W-1:0]  out_k12,
  output logic signed [p1ts_pkg::ENT_W-1:0]  out_k13,
  output logic signed [p1ts_pkg::ENT_W-1:0]  out_k22,
  output logic signed [p1ts_pkg::ENT_W-1:0]  out_k23,
  output logic signed [p1ts_pkg::ENT_W-1:0]  out_k33,
  output logic                               out_degenerate,
  output logic                               out_saturated
);
  import p1ts_pkg::*;

  logic [NS-1:0]             v_r;
  logic [NS-1:0]             v_nxt;
  logic [NS-1:0]             ld;

  logic [IDX_W-1:0]          tag_r [0:NS-1];
  logic                      deg_r [3:NS-1];

  logic signed [DIFF_W-1:0]  ax_r, ay_r, bx_r, by_r;
  logic signed [PROD_W-1:0]  p_axby_r, p_aybx_r, p_bxbx_r, p_byby_r;
  logic signed [PROD_W-1:0]  p_axbx_r, p_ayby_r, p_axax_r, p_ayay_r;
  logic signed [SUM_W-1:0]   det_s_r, s1_r, s2_r, s3_r;
  logic [DET_W-1:0]          dabs_r;
  logic signed [NUM_W-1:0]   n_r   [0:N_ENT-1];
  logic [MAG_W-1:0]          mag_r [0:N_ENT-1];
  logic                      neg_r [0:N_ENT-1];
  logic [DET_W-1:0]          den_r;

  logic signed [NUM_W-1:0]   s1_w, s2_w, s3_w;
  logic signed [SUM_W-1:0]   det_abs_w;
  div_req_t                  req   [0:N_ENT-1];
  div_res_t                  res   [0:N_ENT-1];

  // stage i may load if anything from i to the output is empty, or output drains
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      ld[i] = out_ready || !(&(v_r | ~({NS{1'b1}} << i)));
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (ld[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NS; i++) begin
      if (ld[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = ld[0];

  // tag and degenerate side lines
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      tag_r[0] <= in_element_index;
    end
    for (int i = 1; i < NS; i++) begin
      if (ld[i]) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
    if (ld[3]) begin
      deg_r[3] <= (det_s_r == '0);
    end
    for (int i = 4; i < NS; i++) begin
      if (ld[i]) begin
        deg_r[i] <= deg_r[i-1];
      end
    end
  end

  // stage 0: edge vectors
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ax_r <= DIFF_W'(in_corner2_x) - DIFF_W'(in_corner1_x);
      ay_r <= DIFF_W'(in_corner2_y) - DIFF_W'(in_corner1_y);
      bx_r <= DIFF_W'(in_corner3_x) - DIFF_W'(in_corner1_x);
      by_r <= DIFF_W'(in_corner3_y) - DIFF_W'(in_corner1_y);
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p_axby_r <= ax_r * by_r;
      p_aybx_r <= ay_r * bx_r;
      p_bxbx_r <= bx_r * bx_r;
      p_byby_r <= by_r * by_r;
      p_axbx_r <= ax_r * bx_r;
      p_ayby_r <= ay_r * by_r;
      p_axax_r <= ax_r * ax_r;
      p_ayay_r <= ay_r * ay_r;
    end
  end

  // stage 2: determinant and dot products
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      det_s_r <= SUM_W'(p_axby_r) - SUM_W'(p_aybx_r);
      s1_r    <= SUM_W'(p_bxbx_r) + SUM_W'(p_byby_r);
      s2_r    <= SUM_W'(p_axbx_r) + SUM_W'(p_ayby_r);
      s3_r    <= SUM_W'(p_axax_r) + SUM_W'(p_ayay_r);
    end
  end

  // stage 3: |det| and entry numerators
  assign s1_w      = NUM_W'(s1_r);
  assign s2_w      = NUM_W'(s2_r);
  assign s3_w      = NUM_W'(s3_r);
  assign det_abs_w = det_s_r[SUM_W-1] ? -det_s_r : det_s_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      dabs_r <= det_abs_w[DET_W-1:0];
      n_r[0] <= s1_w + s3_w - (s2_w <<< 1);   // k11
      n_r[1] <= s2_w - s1_w;                  // k12
      n_r[2] <= s2_w - s3_w;                  // k13
      n_r[3] <= s1_w;                         // k22
      n_r[4] <= -s2_w;                        // k23
      n_r[5] <= s3_w;                         // k33
    end
  end

  // stage 4: sign and magnitude
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      den_r <= dabs_r;
      for (int e = 0; e < N_ENT; e++) begin
        neg_r[e] <= n_r[e][NUM_W-1];
        mag_r[e] <= n_r[e][NUM_W-1] ? MAG_W'(-n_r[e]) : MAG_W'(n_r[e]);
      end
    end
  end

  for (genvar e = 0; e < N_ENT; e++) begin : g_lane
    always_comb begin
      req[e].mag  = mag_r[e];
      req[e].neg  = neg_r[e];
      req[e].det  = den_r;
      req[e].zero = deg_r[PRE_ST-1];
    end

    p1ts_div_lane u_lane (
      .clk (clk),
      .ld  (ld[NS-1:PRE_ST]),
      .req (req[e]),
      .res (res[e])
    );
  end

  assign out_valid      = v_r[NS-1];
  assign out_tag_index  = tag_r[NS-1];
  assign out_degenerate = deg_r[NS-1];
  assign out_k11        = res[0].value;
  assign out_k12        = res[1].value;
  assign out_k13        = res[2].value;
  assign out_k22        = res[3].value;
  assign out_k23        = res[4].value;
  assign out_k33        = res[5].value;
  assign out_saturated  = res[0].sat | res[1].sat | res[2].sat |
                          res[3].sat | res[4].sat | res[5].sat;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> (out_k11 == '0) && (out_k12 == '0) &&
      (out_k13 == '0) && (out_k22 == '0) && (out_k23 == '0) &&
      (out_k33 == '0) && !out_saturated)
    else $error("degenerate word with nonzero entries");

  a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_k11[ENT_W-1] && !out_k22[ENT_W-1] && !out_k33[ENT_W-1])
    else $error("negative diagonal entry");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output not blocked");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_k11 == ENT_MAX) || (out_k12 == ENT_MAX) || (out_k13 == ENT_MAX) ||
      (out_k22 == ENT_MAX) || (out_k33 == ENT_MAX) || (out_k23 == ENT_MAX) ||
      (out_k12 == ENT_MIN) || (out_k13 == ENT_MIN) || (out_k23 == ENT_MIN))
    else $error("saturated flag without clipped entry");

endmodule
